>>> rtl/sorted_list_table_core_assert.svh
// Assertion macros for the sorted list table core checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef SORTED_LIST_TABLE_CORE_ASSERT_SVH
`define SORTED_LIST_TABLE_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored during reset
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slt_pkg.sv
// Shared types and constants for the sorted list table core.
// No dependencies.
`default_nettype none

package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_HEAD,
        ST_DEL,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

>>> rtl/sorted_list_table_core.sv
// Sorted list table core: ascending table of signed values in one RAM.
// Depends on slt_pkg.
`default_nettype none

// Channel   Handshake          Beat contents
// command   start / busy       command, value
// result    valid (strobe)     entry_value, position, status, last
//
// Insert: at most one RAM read per entry, scanning from the top and shifting up,
//   plus a separate slot-0 write state when the value lands in slot 0.
// Delete: one read per entry, upward scan, shift down after match.
// Readout: one result beat per cycle, the RAM read port sets the pace.
// Full, empty and ignored commands finish in the accept cycle.
// Results are registered, appearing the cycle after they are formed, and cannot be stalled.
// Reset clears the state, entry count, match flag and result strobe; RAM contents are don't-care.

module sorted_list_table_core
    import slt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              command,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         valid,
    output logic signed [VAL_W-1:0]      entry_value,
    output logic [POS_W-1:0]             position,
    output logic [1:0]                   status,
    output logic                         last
);

    // table storage, one write and one registered read per cycle
    logic [VAL_W-1:0]        mem [CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    logic [VAL_W-1:0]        mem_wd;
    logic [IDX_W-1:0]        mem_ra;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;   // index whose data is in rd_data_reg
    logic [IDX_W-1:0]        lim_reg, lim_next;   // last valid index for the scan
    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    // result staging
    logic                    res_fire;
    logic signed [VAL_W-1:0] res_value;
    logic [POS_W-1:0]        res_pos;
    status_t                 res_status;
    logic                    res_last;

    logic                    valid_reg;
    logic signed [VAL_W-1:0] entry_value_reg;
    logic [POS_W-1:0]        position_reg;
    logic [1:0]              status_reg;
    logic                    last_reg;

    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        ptr_inc, ptr_dec;
    logic                    at_lim, at_zero, hit;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign ptr_inc = ptr_reg + IDX_W'(1);
    assign ptr_dec = ptr_reg - IDX_W'(1);
    assign at_lim  = (ptr_reg == lim_reg);
    assign at_zero = (ptr_reg == '0);
    assign hit     = (rd_data_reg == val_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        lim_reg <= lim_next;
        val_reg <= val_next;
        if (res_fire)
        begin
            entry_value_reg <= res_value;
            position_reg    <= res_pos;
            status_reg      <= res_status;
            last_reg        <= res_last;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        lim_next   = lim_reg;
        found_next = found_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_wa     = ptr_inc;
        mem_wd     = rd_data_reg;
        mem_ra     = ptr_inc;
        res_fire   = 1'b0;
        res_value  = val_reg;
        res_pos    = '0;
        res_status = STS_OK;
        res_last   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next   = value;
                    found_next = 1'b0;
                    res_value  = value;
                    unique case (command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_fire   = 1'b1;
                                res_status = STS_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty table: place directly in slot 0
                                mem_we     = 1'b1;
                                mem_wa     = '0;
                                mem_wd     = value;
                                count_next = CNT_W'(1);
                                res_fire   = 1'b1;
                            end
                            else
                            begin
                                mem_ra     = cnt_m1[IDX_W-1:0];
                                ptr_next   = cnt_m1[IDX_W-1:0];
                                state_next = ST_INS;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_fire   = 1'b1;
                                res_status = STS_NOT_FOUND;
                            end
                            else
                            begin
                                mem_ra     = '0;
                                ptr_next   = '0;
                                lim_next   = cnt_m1[IDX_W-1:0];
                                state_next = ST_DEL;
                            end
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_fire   = 1'b1;
                                res_value  = '0;
                                res_status = STS_EMPTY;
                            end
                            else
                            begin
                                mem_ra     = '0;
                                ptr_next   = '0;
                                lim_next   = cnt_m1[IDX_W-1:0];
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            // undefined command: dropped without a result
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                // walk down from the top; entries not below the operand move up one
                mem_we = 1'b1;
                mem_wa = ptr_inc;
                if (rd_data_reg < val_reg)
                begin
                    mem_wd     = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    res_fire   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (at_zero)
                begin
                    state_next = ST_INS_HEAD;
                end
                else
                begin
                    mem_ra   = ptr_dec;
                    ptr_next = ptr_dec;
                end
            end

            ST_INS_HEAD:
            begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                mem_wd     = val_reg;
                count_next = count_reg + CNT_W'(1);
                res_fire   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_DEL:
            begin
                // after the first match every later entry moves down one
                if (found_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = ptr_dec;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                end
                if (at_lim)
                begin
                    res_fire   = 1'b1;
                    state_next = ST_IDLE;
                    if (found_reg || hit)
                    begin
                        count_next = cnt_m1;
                    end
                    else
                    begin
                        res_status = STS_NOT_FOUND;
                    end
                end
                else
                begin
                    mem_ra   = ptr_inc;
                    ptr_next = ptr_inc;
                end
            end

            ST_READ:
            begin
                res_fire  = 1'b1;
                res_value = rd_data_reg;
                res_pos   = POS_W'(ptr_reg) + POS_W'(1);
                res_last  = at_lim;
                if (at_lim)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_ra   = ptr_inc;
                    ptr_next = ptr_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign entry_value = entry_value_reg;
    assign position    = position_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> rtl/slt_checker.sv
// Port-level checker for sorted_list_table_core, bound into every sorted_list_table_core instance.
// Depends on slt_pkg and sorted_list_table_core_assert.svh.
`default_nettype none

`include "sorted_list_table_core_assert.svh"

module slt_checker
    import slt_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             busy,
    input wire logic             valid,
    input wire logic [POS_W-1:0] position,
    input wire logic [1:0]       status,
    input wire logic             last
);

    // readout beats come back to back and the core stays busy between them
    `SLT_ASSERT_NEXT(a_read_contig, valid && !last, valid, "readout beats not contiguous")
    `SLT_ASSERT_NOW(a_read_busy, valid && !last, busy, "core idle with readout pending")
    // positions count up by one within a readout
    `SLT_ASSERT_NOW(a_pos_step, valid && (position > POS_W'(1)),
        $past(valid) && (position == $past(position) + POS_W'(1)), "readout position skipped")
    // error and empty statuses are single, position-free beats
    `SLT_ASSERT_NOW(a_err_single, valid && (status != STS_OK),
        last && (position == '0), "error beat malformed")

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .valid    (valid),
    .position (position),
    .status   (status),
    .last     (last)
);

`default_nettype wire

>>> test/sorted_list_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_list_table_core: directed and random command beats,
// with every result beat compared against a tracked copy of the table.
// Depends on slt_pkg and the sorted_list_table_core RTL.

module sorted_list_table_core_tb;

    import slt_pkg::*;

    // Command code 3 has no meaning; the core must drop it silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Random beats per idling phase; with directed and ignored beats, about 310 in all.
    localparam int BEATS_PER_PHASE = 90;
    // Settle time after the last expected beat: the longest busy run plus margin.
    localparam int SETTLE_CYCLES   = CAPACITY + 4;

    typedef struct {
        logic signed [VAL_W-1:0] entry_value;
        logic [POS_W-1:0]        position;
        status_t                 status;
        logic                    last;
    } result_beat_t;

    // Tracks table contents, predicts result beats and checks the core's output.
    class table_tracker;
        logic signed [VAL_W-1:0] slots [CAPACITY];
        int                      filled;
        int                      peak_fill;
        result_beat_t            pending_beats[$];
        int                      errors;
        int                      commands;
        int                      ignored;
        int                      beats_checked;
        int                      full_rejects;
        int                      missed_deletes;
        int                      empty_reads;

        function void queue_beat(logic signed [VAL_W-1:0] v, logic [POS_W-1:0] pos,
                                 status_t sts, logic fin);
            result_beat_t b;
            b.entry_value = v;
            b.position    = pos;
            b.status      = sts;
            b.last        = fin;
            pending_beats.push_back(b);
        endfunction

        // Called once per accepted command beat.
        function void note_command(logic [1:0] cmd, logic signed [VAL_W-1:0] val);
            int at;
            int i;
            commands++;
            case (cmd)
                CMD_INSERT: begin
                    if (filled >= CAPACITY) begin
                        queue_beat(val, '0, STS_FULL, 1'b1);
                    end
                    else begin
                        // new value goes ahead of the first entry not smaller
                        at = 0;
                        while (at < filled && slots[at] < val)
                            at++;
                        for (i = filled; i > at; i--)
                            slots[i] = slots[i-1];
                        slots[at] = val;
                        filled++;
                        if (filled > peak_fill)
                            peak_fill = filled;
                        queue_beat(val, '0, STS_OK, 1'b1);
                    end
                end
                CMD_DELETE: begin
                    at = 0;
                    while (at < filled && slots[at] != val)
                        at++;
                    if (at >= filled) begin
                        queue_beat(val, '0, STS_NOT_FOUND, 1'b1);
                    end
                    else begin
                        for (i = at; i + 1 < filled; i++)
                            slots[i] = slots[i+1];
                        filled--;
                        queue_beat(val, '0, STS_OK, 1'b1);
                    end
                end
                CMD_READ: begin
                    if (filled == 0)
                        queue_beat('0, '0, STS_EMPTY, 1'b1);
                    else
                        for (i = 0; i < filled; i++)
                            queue_beat(slots[i], POS_W'(i + 1), STS_OK, (i + 1 == filled));
                end
                default: ignored++;
            endcase
        endfunction

        function void check_beat(logic signed [VAL_W-1:0] got_value,
                                 logic [POS_W-1:0] got_pos,
                                 logic [1:0] got_status, logic got_last);
            result_beat_t want;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected: entry_value %0d status %0d",
                       got_value, got_status);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            beats_checked++;
            case (want.status)
                STS_FULL:      full_rejects++;
                STS_NOT_FOUND: missed_deletes++;
                STS_EMPTY:     empty_reads++;
                default:       ;
            endcase
            if (got_value !== want.entry_value) begin
                $error("entry_value: expected %0d, got %0d", want.entry_value, got_value);
                errors++;
            end
            if (got_pos !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got_pos);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              command = CMD_INSERT;
    logic signed [VAL_W-1:0] value = '0;
    logic                    busy;
    logic                    valid;
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        position;
    logic [1:0]              status;
    logic                    last;

    table_tracker board = new();

    // Percentage of command beats preceded by a gap with start low.
    int idle_pct = 17;
    // Random walk direction: fill toward full, then drain toward empty.
    bit filling = 1'b1;

    sorted_list_table_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .value       (value),
        .valid       (valid),
        .entry_value (entry_value),
        .position    (position),
        .status      (status),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result beats last one cycle and cannot be held off: check every strobe.
    // Sampling at the edge sees pre-edge values, so no race with the core's flops.
    always @(posedge clk)
    begin
        if (rst_n && valid)
            board.check_beat(entry_value, position, status, last);
    end

    // Present one command beat and return at the edge that accepts it.
    // start stays high on return so back-to-back beats need no toggle.
    task automatic issue_command(input logic [1:0] cmd, input logic signed [VAL_W-1:0] val);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 20);    // up to a full busy run, so gaps land anywhere
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(cmd, val);
    endtask

    // Hold off new commands until every expected beat has come out.
    task automatic drain_results();
        start <= 1'b0;
        while (board.pending_beats.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Operand mix: hits on stored values, a small dense range for duplicates,
    // the extremes, and full-width noise.
    function automatic logic signed [VAL_W-1:0] pick_operand(input bit want_hit);
        int sel;
        sel = $urandom_range(0, 9);
        if (want_hit && board.filled > 0 && sel < 6)
            return board.slots[$urandom_range(0, board.filled - 1)];
        if (sel < 5)
            return int'($urandom_range(0, 15)) - 8;
        if (sel < 7)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int k;
        int phase;
        int counted;
        int roll;
        logic [1:0] cmd;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table cases, extremes, duplicates, ignored code,
        // a miss, fill to full with descending inserts, reject, then
        // deletes at head, tail and on a duplicate.
        issue_command(CMD_READ, 0);
        issue_command(CMD_DELETE, 5);
        issue_command(CMD_INSERT, VAL_MAX);
        issue_command(CMD_INSERT, VAL_MIN);
        issue_command(CMD_INSERT, 0);
        issue_command(CMD_INSERT, 0);
        issue_command(CMD_UNUSED, -1);
        issue_command(CMD_READ, 0);
        issue_command(CMD_DELETE, 7);
        for (k = 12; k >= 1; k--)
            issue_command(CMD_INSERT, k);
        issue_command(CMD_INSERT, VAL_MIN);
        issue_command(CMD_READ, $urandom);
        issue_command(CMD_DELETE, VAL_MIN);
        issue_command(CMD_DELETE, VAL_MAX);
        issue_command(CMD_DELETE, 0);
        drain_results();

        // Random: sender idles 17%, then 55%, then never.
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 17 : (phase == 1) ? 55 : 0;
            counted = 0;
            while (counted < BEATS_PER_PHASE)
            begin
                if (board.filled >= CAPACITY && $urandom_range(0, 2) == 0)
                    filling = 1'b0;
                else if (board.filled == 0)
                    filling = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    cmd = CMD_UNUSED;
                else if (roll < 18)
                    cmd = CMD_READ;
                else if (($urandom_range(0, 99) < 75) == filling)
                    cmd = CMD_INSERT;
                else
                    cmd = CMD_DELETE;
                issue_command(cmd, pick_operand(cmd == CMD_DELETE));
                if (cmd != CMD_UNUSED)
                    counted++;
            end
            drain_results();
        end

        $display("Covered %0d command beats (%0d ignored codes), %0d result beats checked.",
                 board.commands, board.ignored, board.beats_checked);
        $display("Full rejects %0d, delete misses %0d, empty readouts %0d, peak fill %0d of %0d.",
                 board.full_rejects, board.missed_deletes, board.empty_reads,
                 board.peak_fill, CAPACITY);
        if (board.errors == 0 && board.pending_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sorted_list_table_core.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/sorted_list_table_core.sv
rtl/slt_checker.sv
test/sorted_list_table_core_tb.sv
